// File: hdl/i2cm_pkg.sv
// Package with item types and codes of the two-wire bus master controller.
`default_nettype none
package i2cm_pkg;

  typedef struct packed {
    logic [1:0]  op;
    logic [2:0]  reg_index;
    logic [7:0]  write_data;
    logic [15:0] tick_cycles;
    logic        device_ack;
    logic [7:0]  device_byte;
    logic        device_byte_ok;
  } in_item_t;

  typedef struct packed {
    logic [7:0] read_data;
    logic [7:0] status_code;
    logic       flag_set;
    logic       irq_pulse;
    logic [2:0] bus_event;
    logic [7:0] bus_byte;
    logic       ack_sent;
  } out_item_t;

  localparam logic [1:0] OP_WRITE = 2'd0;
  localparam logic [1:0] OP_READ  = 2'd1;
  localparam logic [1:0] OP_TICK  = 2'd2;

  localparam logic [2:0] REG_BITRATE = 3'd0;
  localparam logic [2:0] REG_STATUS  = 3'd1;
  localparam logic [2:0] REG_OWNADDR = 3'd2;
  localparam logic [2:0] REG_DATA    = 3'd3;
  localparam logic [2:0] REG_CONTROL = 3'd4;
  localparam logic [2:0] REG_ADDRMSK = 3'd5;

  localparam logic [7:0] CB_FLAG   = 8'h80;
  localparam logic [7:0] CB_ACKEN  = 8'h40;
  localparam logic [7:0] CB_START  = 8'h20;
  localparam logic [7:0] CB_STOP   = 8'h10;
  localparam logic [7:0] CB_COLL   = 8'h08;
  localparam logic [7:0] CB_ENABLE = 8'h04;
  localparam logic [7:0] CB_IRQEN  = 8'h01;

  localparam logic [2:0] EV_NONE  = 3'd0;
  localparam logic [2:0] EV_START = 3'd1;
  localparam logic [2:0] EV_STOP  = 3'd2;
  localparam logic [2:0] EV_WROTE = 3'd3;
  localparam logic [2:0] EV_READ  = 3'd4;

  localparam logic [7:0] ST_NO_INFO     = 8'hF8;
  localparam logic [7:0] ST_START       = 8'h08;
  localparam logic [7:0] ST_REP_START   = 8'h10;
  localparam logic [7:0] ST_MT_SLA_ACK  = 8'h18;
  localparam logic [7:0] ST_MT_SLA_NACK = 8'h20;
  localparam logic [7:0] ST_MT_DAT_ACK  = 8'h28;
  localparam logic [7:0] ST_MT_DAT_NACK = 8'h30;
  localparam logic [7:0] ST_MR_SLA_ACK  = 8'h40;
  localparam logic [7:0] ST_MR_SLA_NACK = 8'h48;
  localparam logic [7:0] ST_MR_DAT_ACK  = 8'h50;
  localparam logic [7:0] ST_MR_DAT_NACK = 8'h58;

  localparam int unsigned CycW = 19;

endpackage
`default_nettype wire

// File: hdl/i2cm_core.sv
// Register file, bus operation sequencer and cycle timer of the controller.
`default_nettype none
module i2cm_core (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               step_i,
  input  wire i2cm_pkg::in_item_t item_i,
  output i2cm_pkg::out_item_t     result_o
);
  import i2cm_pkg::*;

  localparam logic [2:0] LINK_IDLE       = 3'd0;
  localparam logic [2:0] LINK_START_SENT = 3'd1;
  localparam logic [2:0] LINK_MT_ADDR    = 3'd2;
  localparam logic [2:0] LINK_MT_DATA    = 3'd3;
  localparam logic [2:0] LINK_MR_ADDR    = 3'd4;
  localparam logic [2:0] LINK_MR_DATA    = 3'd5;

  localparam logic [2:0] PEND_NONE    = 3'd0;
  localparam logic [2:0] PEND_START   = 3'd1;
  localparam logic [2:0] PEND_ADDR_W  = 3'd2;
  localparam logic [2:0] PEND_ADDR_R  = 3'd3;
  localparam logic [2:0] PEND_DATA_TX = 3'd4;
  localparam logic [2:0] PEND_DATA_RX = 3'd5;
  localparam logic [2:0] PEND_STOP    = 3'd6;

  logic [7:0]      ctrl_q, ctrl_d;
  logic [7:0]      bitrate_q, bitrate_d;
  logic [1:0]      presc_q, presc_d;
  logic [7:0]      own_q, own_d;
  logic [7:0]      mask_q, mask_d;
  logic [7:0]      data_q, data_d;
  logic [7:0]      status_q, status_d;
  logic [2:0]      link_q, link_d;
  logic [2:0]      pend_q, pend_d;
  logic [7:0]      pbyte_q, pbyte_d;
  logic            pack_q, pack_d;
  logic [CycW-1:0] left_q, left_d;

  logic [CycW-1:0] period;
  logic [CycW-1:0] period9;
  logic [CycW-1:0] tick_ext;
  logic [2:0]      shamt;
  logic [7:0]      rd;
  logic [7:0]      wd;
  logic [2:0]      ev_kind;
  logic [7:0]      ev_byte;
  logic            ev_ack;
  logic            irq;

  assign shamt    = {presc_q, 1'b0} + 3'd1;
  assign period   = CycW'(16) + (CycW'(bitrate_q) << shamt);
  assign period9  = (period << 3) + period;
  assign tick_ext = CycW'(item_i.tick_cycles);
  assign wd       = item_i.write_data;

  always_comb begin
    ctrl_d    = ctrl_q;
    bitrate_d = bitrate_q;
    presc_d   = presc_q;
    own_d     = own_q;
    mask_d    = mask_q;
    data_d    = data_q;
    status_d  = status_q;
    link_d    = link_q;
    pend_d    = pend_q;
    pbyte_d   = pbyte_q;
    pack_d    = pack_q;
    left_d    = left_q;
    rd        = 8'h00;
    ev_kind   = EV_NONE;
    ev_byte   = 8'h00;
    ev_ack    = 1'b0;
    irq       = 1'b0;

    case (item_i.op)
      OP_WRITE: begin
        case (item_i.reg_index)
          REG_BITRATE: bitrate_d = wd;
          REG_STATUS:  presc_d = wd[1:0];
          REG_OWNADDR: own_d = wd;
          REG_DATA: begin
            if ((ctrl_q & CB_FLAG) != 8'h00) begin
              ctrl_d = ctrl_q & ~CB_COLL;
            end else begin
              ctrl_d = ctrl_q | CB_COLL;
            end
            data_d = wd;
          end
          REG_CONTROL: begin
            if ((wd & CB_ENABLE) == 8'h00) begin
              ctrl_d   = wd & ~(CB_FLAG | CB_STOP);
              pend_d   = PEND_NONE;
              left_d   = '0;
              link_d   = LINK_IDLE;
              status_d = ST_NO_INFO;
            end else if ((wd & CB_FLAG) == 8'h00) begin
              ctrl_d = (wd & ~(CB_COLL | CB_FLAG)) | (ctrl_q & (CB_COLL | CB_FLAG));
            end else begin
              ctrl_d = (wd & ~(CB_COLL | CB_FLAG)) | (ctrl_q & CB_COLL);
              if ((wd & CB_STOP) != 8'h00) begin
                pend_d = PEND_STOP;
                left_d = period;
                if ((wd & CB_START) != 8'h00) begin
                  // The STOP completes at once and a START is queued behind it.
                  ev_kind  = EV_STOP;
                  link_d   = LINK_IDLE;
                  status_d = ST_NO_INFO;
                  ctrl_d   = ctrl_d & ~CB_STOP;
                  pend_d   = PEND_START;
                end
              end else if ((wd & CB_START) != 8'h00) begin
                pend_d = PEND_START;
                left_d = period;
              end else if (link_q == LINK_START_SENT) begin
                pbyte_d = data_q;
                pend_d  = data_q[0] ? PEND_ADDR_R : PEND_ADDR_W;
                left_d  = period9;
              end else if (link_q == LINK_MT_ADDR || link_q == LINK_MT_DATA) begin
                pbyte_d = data_q;
                pend_d  = PEND_DATA_TX;
                left_d  = period9;
              end else if (link_q == LINK_MR_ADDR || link_q == LINK_MR_DATA) begin
                pack_d = (wd & CB_ACKEN) != 8'h00;
                pend_d = PEND_DATA_RX;
                left_d = period9;
              end
            end
          end
          REG_ADDRMSK: mask_d = wd & 8'hFE;
          default: ;
        endcase
      end
      OP_READ: begin
        case (item_i.reg_index)
          REG_BITRATE: rd = bitrate_q;
          REG_STATUS:  rd = {status_q[7:3], 1'b0, presc_q};
          REG_OWNADDR: rd = own_q;
          REG_DATA:    rd = data_q;
          REG_CONTROL: rd = ctrl_q;
          REG_ADDRMSK: rd = mask_q;
          default:     rd = 8'h00;
        endcase
      end
      OP_TICK: begin
        if (pend_q != PEND_NONE && left_q != '0) begin
          if (left_q <= tick_ext) begin
            pend_d = PEND_NONE;
            left_d = '0;
            case (pend_q)
              PEND_START: begin
                ev_kind  = EV_START;
                status_d = (link_q == LINK_IDLE) ? ST_START : ST_REP_START;
                link_d   = LINK_START_SENT;
                ctrl_d   = ctrl_q | CB_FLAG;
                irq      = ctrl_q[0];
              end
              PEND_ADDR_W: begin
                ev_kind  = EV_WROTE;
                ev_byte  = pbyte_q;
                status_d = item_i.device_ack ? ST_MT_SLA_ACK : ST_MT_SLA_NACK;
                link_d   = LINK_MT_ADDR;
                ctrl_d   = ctrl_q | CB_FLAG;
                irq      = ctrl_q[0];
              end
              PEND_ADDR_R: begin
                ev_kind  = EV_WROTE;
                ev_byte  = pbyte_q;
                status_d = item_i.device_ack ? ST_MR_SLA_ACK : ST_MR_SLA_NACK;
                link_d   = LINK_MR_ADDR;
                ctrl_d   = ctrl_q | CB_FLAG;
                irq      = ctrl_q[0];
              end
              PEND_DATA_TX: begin
                ev_kind  = EV_WROTE;
                ev_byte  = pbyte_q;
                status_d = item_i.device_ack ? ST_MT_DAT_ACK : ST_MT_DAT_NACK;
                link_d   = LINK_MT_DATA;
                ctrl_d   = ctrl_q | CB_FLAG;
                irq      = ctrl_q[0];
              end
              PEND_DATA_RX: begin
                ev_kind  = EV_READ;
                ev_ack   = pack_q;
                data_d   = item_i.device_byte_ok ? item_i.device_byte : 8'hFF;
                status_d = pack_q ? ST_MR_DAT_ACK : ST_MR_DAT_NACK;
                link_d   = LINK_MR_DATA;
                ctrl_d   = ctrl_q | CB_FLAG;
                irq      = ctrl_q[0];
              end
              PEND_STOP: begin
                ev_kind  = EV_STOP;
                link_d   = LINK_IDLE;
                status_d = ST_NO_INFO;
                ctrl_d   = ctrl_q & ~CB_STOP;
              end
              default: ;
            endcase
          end else begin
            left_d = left_q - tick_ext;
          end
        end
      end
      default: ;
    endcase

    result_o.read_data   = rd;
    result_o.status_code = status_d & 8'hF8;
    result_o.flag_set    = ctrl_d[7];
    result_o.irq_pulse   = irq;
    result_o.bus_event   = ev_kind;
    result_o.bus_byte    = ev_byte;
    result_o.ack_sent    = ev_ack;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ctrl_q    <= 8'h00;
      bitrate_q <= 8'h00;
      presc_q   <= 2'd0;
      own_q     <= 8'h00;
      mask_q    <= 8'h00;
      data_q    <= 8'h00;
      status_q  <= ST_NO_INFO;
      link_q    <= LINK_IDLE;
      pend_q    <= PEND_NONE;
      pbyte_q   <= 8'h00;
      pack_q    <= 1'b0;
      left_q    <= '0;
    end else if (step_i) begin
      ctrl_q    <= ctrl_d;
      bitrate_q <= bitrate_d;
      presc_q   <= presc_d;
      own_q     <= own_d;
      mask_q    <= mask_d;
      data_q    <= data_d;
      status_q  <= status_d;
      link_q    <= link_d;
      pend_q    <= pend_d;
      pbyte_q   <= pbyte_d;
      pack_q    <= pack_d;
      left_q    <= left_d;
    end
  end

endmodule
`default_nettype wire

// File: hdl/i2c_master_twi_controller_unit.sv
// Top level of the two-wire bus master controller with input and result registers.
//
//   channel | direction | payload               | handshake
//   in      | input     | in_data_i  (in_item_t)  | in_valid_i / in_stall_o
//   out     | output    | out_data_o (out_item_t) | out_valid_o / out_stall_i
//
// Each item passes through the input register, and its result through the result
// register. A new item can be transferred in every cycle while the result side does
// not stall. The path between the input register and the result register is one pass
// through the register and timer logic.
// Reset empties both registers and restores all control registers.
// A stall on the result side holds the result and, once the input register is
// full, stalls the input side in the same cycle.
`default_nettype none
module i2c_master_twi_controller_unit (
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire logic                in_valid_i,
  output logic                     in_stall_o,
  input  wire i2cm_pkg::in_item_t  in_data_i,
  output logic                     out_valid_o,
  input  wire logic                out_stall_i,
  output i2cm_pkg::out_item_t      out_data_o
);
  import i2cm_pkg::*;

  logic      in_valid_q;
  in_item_t  in_q;
  logic      out_valid_q;
  out_item_t out_q;
  out_item_t result;
  logic      step;
  logic      in_take;

  assign step       = in_valid_q && (!out_valid_q || !out_stall_i);
  assign in_stall_o = in_valid_q && !step;
  assign in_take    = in_valid_i && !in_stall_o;

  i2cm_core u_core (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .step_i   (step),
    .item_i   (in_q),
    .result_o (result)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (in_take) begin
        in_valid_q <= 1'b1;
      end else if (step) begin
        in_valid_q <= 1'b0;
      end
      if (step) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_take) begin
      in_q <= in_data_i;
    end
    if (step) begin
      out_q <= result;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

endmodule
`default_nettype wire

// File: bench/tb_i2c_master_twi_controller_unit.sv
// Testbench for the two-wire bus master controller: directed table, random bus transactions, noise items.
`default_nettype none
module tb_i2c_master_twi_controller_unit;
  timeunit 1ns;
  timeprecision 1ps;

  import i2cm_pkg::*;

  localparam logic [1:0] OP_UNUSED = 2'd3;
  localparam logic [2:0] REG_LAST  = 3'd7;
  localparam int unsigned ITEM_GOAL = 1800;

  typedef enum logic [2:0] {
    LINK_IDLE, LINK_START_SENT, LINK_MT_ADDR, LINK_MT_DATA, LINK_MR_ADDR, LINK_MR_DATA
  } link_e;

  typedef enum logic [2:0] {
    PEND_NONE, PEND_START, PEND_ADDR_W, PEND_ADDR_R, PEND_DATA_TX, PEND_DATA_RX, PEND_STOP
  } pend_e;

  typedef struct {
    in_item_t  item;
    bit        typed;
    out_item_t res;
  } plan_row_t;

  logic      clk_i = 1'b0;
  logic      rst_ni;
  logic      in_valid_i;
  logic      in_stall_o;
  in_item_t  in_data_i;
  logic      out_valid_o;
  logic      out_stall_i = 1'b0;
  out_item_t out_data_o;

  i2c_master_twi_controller_unit u_dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .in_data_i   (in_data_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_data_o  (out_data_o)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // Shadow copy of the controller registers and the bus operation in flight.
  logic [7:0]  m_ctrl, m_bitrate, m_own, m_mask, m_data, m_status, m_pbyte;
  logic [1:0]  m_presc;
  logic        m_pack;
  logic [18:0] m_left;
  link_e       m_link;
  pend_e       m_pend;
  out_item_t   pr;

  out_item_t   expected_q[$];
  plan_row_t   plan[$];

  int unsigned n_sent, n_checked, n_errors, n_irq;
  int unsigned n_ev[5];
  int          burst_left;
  bit          drain_req;

  function automatic void shadow_reset();
    m_ctrl = '0; m_bitrate = '0; m_presc = '0; m_own = '0; m_mask = '0; m_data = '0;
    m_status = ST_NO_INFO; m_link = LINK_IDLE; m_pend = PEND_NONE;
    m_pbyte = '0; m_pack = 1'b0; m_left = '0;
  endfunction

  function automatic logic [18:0] bit_period();
    int unsigned factor;
    factor = 1 << (2 * m_presc);
    return 19'(16 + 2 * int'(m_bitrate) * factor);
  endfunction

  function automatic void raise_flag();
    m_ctrl = m_ctrl | CB_FLAG;
    if ((m_ctrl & CB_IRQEN) != 0) pr.irq_pulse = 1'b1;
  endfunction

  function automatic void complete_op(logic ack, logic [7:0] dev_byte, logic dev_ok);
    pend_e kind;
    kind = m_pend;
    m_pend = PEND_NONE;
    m_left = '0;
    case (kind)
      PEND_START: begin
        pr.bus_event = EV_START;
        m_status = (m_link == LINK_IDLE) ? ST_START : ST_REP_START;
        m_link = LINK_START_SENT;
        raise_flag();
      end
      PEND_ADDR_W, PEND_ADDR_R, PEND_DATA_TX: begin
        pr.bus_event = EV_WROTE;
        pr.bus_byte = m_pbyte;
        if (kind == PEND_ADDR_W) begin
          m_status = ack ? ST_MT_SLA_ACK : ST_MT_SLA_NACK;
          m_link = LINK_MT_ADDR;
        end else if (kind == PEND_ADDR_R) begin
          m_status = ack ? ST_MR_SLA_ACK : ST_MR_SLA_NACK;
          m_link = LINK_MR_ADDR;
        end else begin
          m_status = ack ? ST_MT_DAT_ACK : ST_MT_DAT_NACK;
          m_link = LINK_MT_DATA;
        end
        raise_flag();
      end
      PEND_DATA_RX: begin
        pr.bus_event = EV_READ;
        pr.ack_sent = m_pack;
        m_data = dev_ok ? dev_byte : 8'hFF;
        m_status = m_pack ? ST_MR_DAT_ACK : ST_MR_DAT_NACK;
        m_link = LINK_MR_DATA;
        raise_flag();
      end
      PEND_STOP: begin
        pr.bus_event = EV_STOP;
        m_link = LINK_IDLE;
        m_status = ST_NO_INFO;
        m_ctrl = m_ctrl & ~CB_STOP;
      end
      default: ;
    endcase
  endfunction

  function automatic void control_write(logic [7:0] v);
    logic [18:0] per;
    if ((v & CB_ENABLE) == 0) begin
      m_ctrl = v & ~(CB_FLAG | CB_STOP);
      m_pend = PEND_NONE;
      m_left = '0;
      m_link = LINK_IDLE;
      m_status = ST_NO_INFO;
      return;
    end
    if ((v & CB_FLAG) == 0) begin
      m_ctrl = (v & ~(CB_COLL | CB_FLAG)) | (m_ctrl & (CB_COLL | CB_FLAG));
      return;
    end
    m_ctrl = (v & ~(CB_COLL | CB_FLAG)) | (m_ctrl & CB_COLL);
    per = bit_period();
    if ((v & CB_STOP) != 0) begin
      m_pend = PEND_STOP;
      m_left = per;
      if ((v & CB_START) != 0) begin
        complete_op(1'b0, 8'h00, 1'b0);
        m_pend = PEND_START;
        m_left = per;
      end
    end else if ((v & CB_START) != 0) begin
      m_pend = PEND_START;
      m_left = per;
    end else begin
      case (m_link)
        LINK_START_SENT: begin
          m_pbyte = m_data;
          m_pend = m_data[0] ? PEND_ADDR_R : PEND_ADDR_W;
          m_left = 19'(9 * int'(per));
        end
        LINK_MT_ADDR, LINK_MT_DATA: begin
          m_pbyte = m_data;
          m_pend = PEND_DATA_TX;
          m_left = 19'(9 * int'(per));
        end
        LINK_MR_ADDR, LINK_MR_DATA: begin
          m_pack = ((v & CB_ACKEN) != 0);
          m_pend = PEND_DATA_RX;
          m_left = 19'(9 * int'(per));
        end
        default: ;
      endcase
    end
  endfunction

  function automatic out_item_t controller_predict(in_item_t it);
    pr = '0;
    case (it.op)
      OP_WRITE: begin
        case (it.reg_index)
          REG_BITRATE: m_bitrate = it.write_data;
          REG_STATUS:  m_presc = it.write_data[1:0];
          REG_OWNADDR: m_own = it.write_data;
          REG_DATA: begin
            if ((m_ctrl & CB_FLAG) != 0) m_ctrl = m_ctrl & ~CB_COLL;
            else m_ctrl = m_ctrl | CB_COLL;
            m_data = it.write_data;
          end
          REG_CONTROL: control_write(it.write_data);
          REG_ADDRMSK: m_mask = it.write_data & 8'hFE;
          default: ;
        endcase
      end
      OP_READ: begin
        case (it.reg_index)
          REG_BITRATE: pr.read_data = m_bitrate;
          REG_STATUS:  pr.read_data = {m_status[7:3], 1'b0, m_presc};
          REG_OWNADDR: pr.read_data = m_own;
          REG_DATA:    pr.read_data = m_data;
          REG_CONTROL: pr.read_data = m_ctrl;
          REG_ADDRMSK: pr.read_data = m_mask;
          default:     pr.read_data = '0;
        endcase
      end
      OP_TICK: begin
        if (m_pend != PEND_NONE && m_left != 0) begin
          if (m_left <= 19'(it.tick_cycles))
            complete_op(it.device_ack, it.device_byte, it.device_byte_ok);
          else
            m_left = m_left - 19'(it.tick_cycles);
        end
      end
      default: ;
    endcase
    pr.status_code = m_status & 8'hF8;
    pr.flag_set = m_ctrl[7];
    return pr;
  endfunction

  function automatic in_item_t wr_item(logic [2:0] idx, logic [7:0] wd);
    in_item_t it;
    it = '0;
    it.op = OP_WRITE;
    it.reg_index = idx;
    it.write_data = wd;
    return it;
  endfunction

  function automatic in_item_t rd_item(logic [2:0] idx);
    in_item_t it;
    it = '0;
    it.op = OP_READ;
    it.reg_index = idx;
    return it;
  endfunction

  function automatic in_item_t tick_item(logic [15:0] cyc, logic ack, logic [7:0] b, logic ok);
    in_item_t it;
    it = '0;
    it.op = OP_TICK;
    it.tick_cycles = cyc;
    it.device_ack = ack;
    it.device_byte = b;
    it.device_byte_ok = ok;
    return it;
  endfunction

  function automatic out_item_t mk_res(logic [7:0] rd, logic [7:0] st, logic fl, logic irq,
                                       logic [2:0] ev, logic [7:0] bb, logic ack);
    out_item_t r;
    r.read_data = rd;
    r.status_code = st;
    r.flag_set = fl;
    r.irq_pulse = irq;
    r.bus_event = ev;
    r.bus_byte = bb;
    r.ack_sent = ack;
    return r;
  endfunction

  function automatic void plan_add(in_item_t it);
    plan.push_back('{item: it, typed: 1'b0, res: '0});
  endfunction

  function automatic void plan_add_typed(in_item_t it, out_item_t r);
    plan.push_back('{item: it, typed: 1'b1, res: r});
  endfunction

  task automatic send(in_item_t it, bit typed = 1'b0, out_item_t res = '0);
    out_item_t p;
    int gap;
    p = controller_predict(it);
    expected_q.push_back(typed ? res : p);
    in_data_i <= it;
    in_valid_i <= 1'b1;
    do @(posedge clk_i); while (in_stall_o);
    if (!(it.op == OP_UNUSED || (it.op == OP_WRITE && it.reg_index > REG_ADDRMSK)))
      n_sent++;
    gap = 0;
    burst_left--;
    if (burst_left <= 0) begin
      burst_left = $urandom_range(1, 40);
      gap = ($urandom_range(0, 7) == 0) ? $urandom_range(1, 20) : $urandom_range(0, 3);
    end
    if (drain_req && gap == 0) gap = 1;
    if (gap != 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
      if (drain_req) begin
        while (expected_q.size() != 0) @(posedge clk_i);
        drain_req = 1'b0;
      end
    end
  endtask

  task automatic go(logic [7:0] bits);
    send(wr_item(REG_CONTROL, CB_FLAG | CB_ENABLE | bits |
                 (8'($urandom) & (CB_ACKEN | CB_COLL))));
  endtask

  // Feed ticks, with occasional register reads, until the bus operation in flight completes.
  task automatic run_op();
    int r;
    int lim;
    logic [15:0] cyc;
    while (m_pend != PEND_NONE) begin
      r = $urandom_range(0, 9);
      lim = (m_left > 19'd65535) ? 65535 : int'(m_left);
      if (r == 0) begin
        send(rd_item(3'($urandom_range(REG_BITRATE, REG_ADDRMSK))));
      end else begin
        if (r < 4) cyc = 16'(lim);
        else if (r < 5) cyc = 16'(lim - 1);
        else if (r < 8) cyc = 16'($urandom_range(0, lim));
        else cyc = 16'($urandom);
        send(tick_item(cyc, 1'($urandom), 8'($urandom), $urandom_range(0, 7) != 0));
      end
    end
  endtask

  task automatic set_timing();
    int r;
    logic [7:0] br;
    logic [1:0] ps;
    r = $urandom_range(0, 19);
    if (r == 0) begin
      br = 8'hFF;
      ps = 2'd3;
    end else if (r < 3) begin
      br = 8'($urandom);
      ps = 2'($urandom_range(0, 1));
    end else begin
      br = 8'($urandom_range(0, 3));
      ps = 2'($urandom);
    end
    send(wr_item(REG_BITRATE, br));
    send(wr_item(REG_STATUS, {6'($urandom), ps}));
  endtask

  task automatic bus_transaction();
    logic [7:0] ie;
    logic       rw;
    int         segs;
    int         ending;
    bit         more;
    ie = ($urandom_range(0, 1) != 0) ? CB_IRQEN : 8'h00;
    if ($urandom_range(0, 4) == 0) set_timing();
    go(CB_START | ie);
    run_op();
    segs = 0;
    more = 1'b1;
    while (more) begin
      rw = 1'($urandom);
      send(wr_item(REG_DATA, {7'($urandom), rw}));
      go(ie);
      run_op();
      repeat ($urandom_range(0, 4)) begin
        if (!rw) send(wr_item(REG_DATA, 8'($urandom)));
        go(ie);
        run_op();
        if ($urandom_range(0, 5) == 0) send(rd_item(REG_DATA));
      end
      segs++;
      ending = $urandom_range(0, 9);
      if (segs < 3 && ending == 7) begin
        go(CB_STOP | CB_START | ie);
        run_op();
      end else if (segs < 3 && ending == 8) begin
        go(CB_START | ie);
        run_op();
      end else if (ending == 9) begin
        send(wr_item(REG_CONTROL, 8'($urandom) & ~CB_ENABLE));
        more = 1'b0;
      end else begin
        go(CB_STOP | ie);
        run_op();
        more = 1'b0;
      end
    end
  endtask

  task automatic noise_item();
    in_item_t it;
    it.op = 2'($urandom_range(OP_WRITE, OP_UNUSED));
    it.reg_index = 3'($urandom_range(REG_BITRATE, REG_LAST));
    it.write_data = 8'($urandom);
    it.tick_cycles = 16'($urandom);
    it.device_ack = 1'($urandom);
    it.device_byte = 8'($urandom);
    it.device_byte_ok = 1'($urandom);
    send(it);
  endtask

  task automatic report(string what, out_item_t e, out_item_t a);
    n_errors++;
    if (n_errors <= 10)
      $display("%s at result %0d: exp rd=%h st=%h fl=%b irq=%b ev=%0d bb=%h ack=%b | got rd=%h st=%h fl=%b irq=%b ev=%0d bb=%h ack=%b",
               what, n_checked, e.read_data, e.status_code, e.flag_set, e.irq_pulse,
               e.bus_event, e.bus_byte, e.ack_sent, a.read_data, a.status_code,
               a.flag_set, a.irq_pulse, a.bus_event, a.bus_byte, a.ack_sent);
  endtask

  out_item_t mon_exp;
  int        stall_mode;
  int        stall_len;

  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (expected_q.size() == 0) begin
        report("Unexpected result", '0, out_data_o);
      end else begin
        mon_exp = expected_q.pop_front();
        if (out_data_o.read_data !== mon_exp.read_data ||
            out_data_o.status_code !== mon_exp.status_code ||
            out_data_o.flag_set !== mon_exp.flag_set ||
            out_data_o.irq_pulse !== mon_exp.irq_pulse ||
            out_data_o.bus_event !== mon_exp.bus_event ||
            out_data_o.bus_byte !== mon_exp.bus_byte ||
            out_data_o.ack_sent !== mon_exp.ack_sent)
          report("Mismatch", mon_exp, out_data_o);
      end
      n_checked++;
      if (out_data_o.bus_event <= EV_READ) n_ev[out_data_o.bus_event]++;
      if (out_data_o.irq_pulse === 1'b1) n_irq++;
    end
    if (stall_len <= 0) begin
      stall_mode = $urandom_range(0, 3);
      stall_len = $urandom_range(10, 150);
    end
    stall_len--;
    case (stall_mode)
      0: out_stall_i <= 1'b0;
      1: out_stall_i <= ($urandom_range(0, 3) == 0);
      2: out_stall_i <= ($urandom_range(0, 3) != 0);
      default: out_stall_i <= ((stall_len / 8) % 2 == 1);
    endcase
  end

  initial begin
    #5_000_000;
    $display("Timeout waiting for results");
    $display("Mismatches found");
    $finish;
  end

  initial begin
    rst_ni = 1'b0;
    in_valid_i = 1'b0;
    in_data_i = '0;
    n_sent = 0; n_checked = 0; n_errors = 0; n_irq = 0;
    foreach (n_ev[k]) n_ev[k] = 0;
    burst_left = 0;
    drain_req = 1'b0;
    stall_len = 0;
    stall_mode = 0;
    shadow_reset();

    plan_add_typed(rd_item(REG_STATUS), mk_res(ST_NO_INFO, ST_NO_INFO, 0, 0, EV_NONE, 0, 0));
    plan_add_typed(rd_item(REG_LAST), mk_res(8'h00, ST_NO_INFO, 0, 0, EV_NONE, 0, 0));
    plan_add_typed('{op: OP_UNUSED, reg_index: REG_LAST, write_data: 8'hFF,
                     tick_cycles: 16'hFFFF, device_ack: 1'b1, device_byte: 8'hFF,
                     device_byte_ok: 1'b1},
                   mk_res(8'h00, ST_NO_INFO, 0, 0, EV_NONE, 0, 0));
    plan_add_typed(wr_item(REG_STATUS, 8'hFF), mk_res(8'h00, ST_NO_INFO, 0, 0, EV_NONE, 0, 0));
    plan_add_typed(rd_item(REG_STATUS), mk_res(8'hFB, ST_NO_INFO, 0, 0, EV_NONE, 0, 0));
    plan_add(wr_item(REG_STATUS, 8'h00));
    plan_add(wr_item(REG_OWNADDR, 8'hFF));
    plan_add_typed(rd_item(REG_OWNADDR), mk_res(8'hFF, ST_NO_INFO, 0, 0, EV_NONE, 0, 0));
    plan_add(wr_item(REG_ADDRMSK, 8'hFF));
    plan_add_typed(rd_item(REG_ADDRMSK), mk_res(8'hFE, ST_NO_INFO, 0, 0, EV_NONE, 0, 0));
    plan_add(wr_item(REG_DATA, 8'hA4));
    plan_add(wr_item(REG_CONTROL, CB_FLAG | CB_ENABLE | CB_IRQEN));
    plan_add(wr_item(REG_CONTROL, CB_FLAG | CB_START | CB_ENABLE | CB_IRQEN));
    plan_add(tick_item(16'd15, 1'b0, 8'h00, 1'b0));
    plan_add_typed(tick_item(16'd1, 1'b0, 8'h00, 1'b0),
                   mk_res(8'h00, ST_START, 1, 1, EV_START, 8'h00, 0));
    plan_add(wr_item(REG_DATA, 8'hA4));
    plan_add(wr_item(REG_CONTROL, CB_FLAG | CB_ENABLE | CB_IRQEN));
    plan_add_typed(tick_item(16'hFFFF, 1'b1, 8'h00, 1'b0),
                   mk_res(8'h00, ST_MT_SLA_ACK, 1, 1, EV_WROTE, 8'hA4, 0));
    plan_add(wr_item(REG_DATA, 8'hFF));
    plan_add(wr_item(REG_CONTROL, CB_FLAG | CB_ENABLE | CB_IRQEN));
    plan_add_typed(tick_item(16'hFFFF, 1'b0, 8'h00, 1'b0),
                   mk_res(8'h00, ST_MT_DAT_NACK, 1, 1, EV_WROTE, 8'hFF, 0));
    plan_add(wr_item(REG_CONTROL, CB_FLAG | CB_START | CB_STOP | CB_ENABLE | CB_IRQEN));
    plan_add(tick_item(16'hFFFF, 1'b0, 8'h00, 1'b0));
    plan_add(wr_item(REG_DATA, 8'hFF));
    plan_add(wr_item(REG_CONTROL, CB_FLAG | CB_ENABLE | CB_IRQEN));
    plan_add(tick_item(16'hFFFF, 1'b1, 8'h00, 1'b0));
    plan_add(wr_item(REG_CONTROL, CB_FLAG | CB_ACKEN | CB_ENABLE | CB_IRQEN));
    plan_add(tick_item(16'hFFFF, 1'b0, 8'h00, 1'b0));
    plan_add(wr_item(REG_CONTROL, CB_FLAG | CB_ENABLE));
    plan_add(tick_item(16'hFFFF, 1'b0, 8'h5A, 1'b1));
    plan_add(wr_item(REG_CONTROL, CB_START | CB_ENABLE));
    plan_add(wr_item(REG_CONTROL, CB_FLAG | CB_STOP | CB_ENABLE));
    plan_add(tick_item(16'hFFFF, 1'b0, 8'h00, 1'b0));
    plan_add(wr_item(REG_CONTROL, 8'h00));
    plan_add(rd_item(REG_CONTROL));

    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (plan[i]) send(plan[i].item, plan[i].typed, plan[i].res);

    drain_req = 1'b1;
    while (n_sent < ITEM_GOAL) begin
      if ($urandom_range(0, 4) == 0) begin
        repeat ($urandom_range(1, 3)) noise_item();
      end else begin
        bus_transaction();
        if ($urandom_range(0, 39) == 0) drain_req = 1'b1;
      end
    end
    in_valid_i <= 1'b0;

    while (expected_q.size() != 0) @(posedge clk_i);
    repeat (10) @(posedge clk_i);
    if (expected_q.size() != 0) begin
      n_errors++;
      $display("%0d expected results never arrived", expected_q.size());
    end

    $display("Sent %0d register and tick transfers, checked %0d results, %0d errors.",
             n_sent, n_checked, n_errors);
    $display("Bus events seen: %0d start, %0d stop, %0d byte written, %0d byte read, %0d irq.",
             n_ev[EV_START], n_ev[EV_STOP], n_ev[EV_WROTE], n_ev[EV_READ], n_irq);
    if (n_errors == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule
`default_nettype wire

// File: filelist.f
hdl/i2cm_pkg.sv
hdl/i2cm_core.sv
hdl/i2c_master_twi_controller_unit.sv
bench/tb_i2c_master_twi_controller_unit.sv
